// ===== design/qped_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qped_pkg
// Types and constants shared by the query parameter extract/decode block.
// ----------------------------------------------------------------------------
package qped_pkg;

   // Input word: one query character and its end-of-string flag.
   typedef struct packed {
      logic [7:0] query_byte;
      logic       last_byte;
   } req_word_type;

   // Result word: an optional decoded byte and an optional final status.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_valid;
      logic       done_res;
      logic [2:0] status;
      logic [8:0] value_length;
   } rsp_word_type;

   // Character classes of one query byte.
   typedef struct packed {
      logic       is_unreserved;
      logic       is_hex;
      logic [3:0] hex_value;
      logic       is_sep;
      logic       is_pct;
      logic       is_plus;
      logic       is_eq;
   } char_class_type;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_KEY_BYTES  = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd2;

   // Final status codes.
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_RESERVED  = 3'd2;
   localparam logic [2:0] ST_NO_EQ     = 3'd3;
   localparam logic [2:0] ST_BAD_HEX   = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;

   // Special characters.
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // Reset value of the length limit register.
   localparam logic [8:0] MAX_LENGTH_RESET = 9'd256;

endpackage

// ===== design/query_param_extract_decode_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_param_extract_decode_core
// Streams a URL query string one character per word, finds the parameter
// whose name equals the configured key and percent-decodes its value.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input register, is decoded there
//   combinationally, and its result is loaded into the result register.
// Throughput: one word per cycle; a held word that makes a result waits while
//   a stalled result sits in the result register, and req_stall rises then.
// Reset: synchronous, active high; clears the scanner to the name phase and
//   the registers to key empty, key length 0, max length 256.
// ----------------------------------------------------------------------------
module query_param_extract_decode_core #(
   parameter int KEY_MAX    = 8,
   parameter int LENGTH_MAX = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   // query character words
   input  logic                    req_valid,
   output logic                    req_stall,
   input  qped_pkg::req_word_type  req_word,
   // result words
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output qped_pkg::rsp_word_type  rsp_word,
   // register writes
   input  logic                    csr_write,
   input  logic [1:0]              csr_index,
   input  logic [63:0]             csr_wdata
);
   import qped_pkg::*;

   // Scanner phases, one-hot.
   typedef enum logic [2:0] {
      PH_NAME  = 3'b001,
      PH_VALUE = 3'b010,
      PH_DRAIN = 3'b100
   } phase_type;

   // Escape progress inside a value.
   localparam logic [1:0] ESC_NONE   = 2'd0;
   localparam logic [1:0] ESC_FIRST  = 2'd1;
   localparam logic [1:0] ESC_SECOND = 2'd2;

   localparam int          KEY_W   = 8 * KEY_MAX;
   localparam logic [3:0]  KEY_CAP = 4'(KEY_MAX);
   // the length limit never exceeds what the 9-bit register can hold
   localparam logic [8:0]  LEN_CAP = (LENGTH_MAX > 511) ? 9'd511 : 9'(LENGTH_MAX);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [KEY_W-1:0] key_ff;
   logic [3:0]       key_len_ff;
   logic [8:0]       max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         key_len_ff <= '0;
         max_len_ff <= MAX_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_BYTES:  key_ff     <= csr_wdata[KEY_W-1:0];
            CSR_KEY_LENGTH: key_len_ff <= csr_wdata[3:0];
            CSR_MAX_LENGTH: max_len_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Effective key length and length limit.
   logic [3:0] klen;
   logic [8:0] limit;

   always_comb begin
      klen  = (key_len_ff > KEY_CAP) ? KEY_CAP : key_len_ff;
      limit = (max_len_ff < LEN_CAP) ? max_len_ff : LEN_CAP;
   end

   // ---------------------------------------------------------------------
   // Input register: holds one word for the decode step
   // ---------------------------------------------------------------------
   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;
   logic         req_take;
   logic         fire;

   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
   end

   // ---------------------------------------------------------------------
   // Character classes of the held word
   // ---------------------------------------------------------------------
   char_class_type cls;

   qped_classify u_classify (
      .query_char (in_word_ff.query_byte),
      .char_class (cls)
   );

   // ---------------------------------------------------------------------
   // Scanner state
   // ---------------------------------------------------------------------
   phase_type  phase_ff,  phase_in;
   logic [3:0] pos_ff,    pos_in;     // key characters matched so far
   logic       lost_ff,   lost_in;    // name failed, or value skipped
   logic [1:0] esc_ff,    esc_in;
   logic [3:0] nib_ff,    nib_in;     // high hex digit of an escape
   logic       hexbad_ff, hexbad_in;  // first escape digit was not hex
   logic [8:0] count_ff,  count_in;   // decoded bytes of this value

   // Pick the key character at the current match position.
   logic [7:0] key_char;

   always_comb begin
      key_char = '0;
      for (int i = 0; i < KEY_MAX; i++) begin
         if (pos_ff == 4'(i)) begin
            key_char = key_ff[8*i +: 8];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Decode step: one character against the scanner state
   // ---------------------------------------------------------------------
   logic       c_last;
   logic [7:0] c_byte;
   logic       name_hit;
   logic       match_ok;
   logic       clear_seg;
   logic       res_make;
   logic       res_data_valid;
   logic [7:0] res_byte;
   logic       res_done;
   logic [2:0] res_status;
   logic [8:0] res_length;

   always_comb begin
      c_last   = in_word_ff.last_byte;
      c_byte   = in_word_ff.query_byte;
      name_hit = !lost_ff && (pos_ff == klen);
      match_ok = !lost_ff && (pos_ff < klen) && (key_char == c_byte);

      phase_in       = phase_ff;
      pos_in         = pos_ff;
      lost_in        = lost_ff;
      esc_in         = esc_ff;
      nib_in         = nib_ff;
      hexbad_in      = hexbad_ff;
      count_in       = count_ff;
      clear_seg      = 1'b0;
      res_data_valid = 1'b0;
      res_byte       = '0;
      res_done       = 1'b0;
      res_status     = ST_FOUND;
      res_length     = '0;

      unique case (phase_ff)
         PH_NAME: begin
            if (cls.is_eq) begin
               // open the value: decode it only if the whole key matched
               pos_in    = '0;
               lost_in   = !name_hit;
               esc_in    = ESC_NONE;
               nib_in    = '0;
               hexbad_in = 1'b0;
               count_in  = '0;
               phase_in  = PH_VALUE;
               if (c_last) begin
                  res_done   = 1'b1;
                  res_status = name_hit ? ST_FOUND : ST_NOT_FOUND;
               end
            end else begin
               // compare first, then check for a reserved character
               if (match_ok) begin
                  pos_in = pos_ff + 4'd1;
               end else begin
                  lost_in = 1'b1;
               end
               if (!cls.is_unreserved) begin
                  res_done   = 1'b1;
                  res_status = ST_RESERVED;
               end else if (c_last) begin
                  res_done   = 1'b1;
                  res_status = ST_NO_EQ;
               end
            end
         end

         PH_VALUE: begin
            if (lost_ff) begin
               // skip a value that is not ours
               if (cls.is_sep) begin
                  clear_seg = 1'b1;
                  phase_in  = PH_NAME;
                  if (c_last) begin
                     // an empty segment follows with no '='
                     res_done   = 1'b1;
                     res_status = ST_NO_EQ;
                  end
               end else if (c_last) begin
                  res_done   = 1'b1;
                  res_status = ST_NOT_FOUND;
               end
            end else if (cls.is_sep) begin
               res_done   = 1'b1;
               res_status = (esc_ff != ESC_NONE) ? ST_TRUNCATED : ST_FOUND;
            end else begin
               case (esc_ff)
                  ESC_NONE: begin
                     if (count_ff >= limit) begin
                        res_done   = 1'b1;
                        res_status = ST_OVERFLOW;
                     end else if (cls.is_pct) begin
                        esc_in    = ESC_FIRST;
                        hexbad_in = 1'b0;
                        if (c_last) begin
                           res_done   = 1'b1;
                           res_status = ST_TRUNCATED;
                        end
                     end else begin
                        res_data_valid = 1'b1;
                        res_byte       = cls.is_plus ? CH_SPACE : c_byte;
                     end
                  end
                  ESC_FIRST: begin
                     if (cls.is_hex) begin
                        nib_in = cls.hex_value;
                     end else begin
                        hexbad_in = 1'b1;
                     end
                     esc_in = ESC_SECOND;
                     if (c_last) begin
                        res_done   = 1'b1;
                        res_status = ST_TRUNCATED;
                     end
                  end
                  default: begin
                     esc_in = ESC_NONE;
                     if (hexbad_ff || !cls.is_hex) begin
                        res_done   = 1'b1;
                        res_status = ST_BAD_HEX;
                     end else begin
                        res_data_valid = 1'b1;
                        res_byte       = {nib_ff, cls.hex_value};
                     end
                  end
               endcase
               if (res_data_valid) begin
                  count_in = count_ff + 9'd1;
                  if (c_last) begin
                     res_done   = 1'b1;
                     res_status = ST_FOUND;
                  end
               end
            end
         end

         PH_DRAIN: begin
            // drop the rest of a finished string
            if (c_last) begin
               clear_seg = 1'b1;
               phase_in  = PH_NAME;
            end
         end

         default: begin
            phase_in = PH_NAME;
         end
      endcase

      // length counts a byte emitted with the final status
      if (res_done && (res_status == ST_FOUND)) begin
         res_length = count_in;
      end

      if (clear_seg || res_done) begin
         pos_in    = '0;
         lost_in   = 1'b0;
         esc_in    = ESC_NONE;
         nib_in    = '0;
         hexbad_in = 1'b0;
         count_in  = '0;
      end
      if (res_done) begin
         phase_in = c_last ? PH_NAME : PH_DRAIN;
      end

      res_make = res_data_valid || res_done;
   end

   // Advance the held word unless its result would hit a stalled output.
   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign fire = in_valid_ff && (!res_make || !rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NAME;
         pos_ff    <= '0;
         lost_ff   <= 1'b0;
         esc_ff    <= ESC_NONE;
         nib_ff    <= '0;
         hexbad_ff <= 1'b0;
         count_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         lost_ff   <= lost_in;
         esc_ff    <= esc_in;
         nib_ff    <= nib_in;
         hexbad_ff <= hexbad_in;
         count_ff  <= count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   always_comb begin
      rsp_word_in.data_byte    = res_byte;
      rsp_word_in.data_valid   = res_data_valid;
      rsp_word_in.done_res     = res_done;
      rsp_word_in.status       = res_status;
      rsp_word_in.value_length = res_length;

      if (fire && res_make) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_make) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      fire && res_make |=> rsp_valid_ff)
      else $error("result word not loaded into result register");

   a_escape_in_value: assert property (@(posedge clock) disable iff (reset)
      (esc_ff != ESC_NONE) |-> (phase_ff == PH_VALUE) && !lost_ff)
      else $error("escape in progress outside a decoded value");

   a_done_leaves_value: assert property (@(posedge clock) disable iff (reset)
      fire && res_done |=> (phase_ff != PH_VALUE) && (count_ff == 9'd0))
      else $error("final status did not close the segment");

   a_data_from_match: assert property (@(posedge clock) disable iff (reset)
      fire && res_data_valid |=> (count_ff != 9'd0) || rsp_word_ff.done_res)
      else $error("decoded byte emitted without being counted");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= KEY_CAP)
      else $error("match position beyond the key");

endmodule

// ===== design/qped_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qped_classify
// Classifies one query character: unreserved, hex digit and its value,
// separator, escape, plus and equals.
// ----------------------------------------------------------------------------
module qped_classify (
   input  logic [7:0]                query_char,
   output qped_pkg::char_class_type  char_class
);
   import qped_pkg::*;

   logic is_digit;
   logic is_upper;
   logic is_lower;
   logic is_hex_alpha;

   always_comb begin
      is_digit     = (query_char >= 8'h30) && (query_char <= 8'h39);
      is_upper     = (query_char >= 8'h41) && (query_char <= 8'h5A);
      is_lower     = (query_char >= 8'h61) && (query_char <= 8'h7A);
      is_hex_alpha = ((query_char >= 8'h41) && (query_char <= 8'h46)) ||
                     ((query_char >= 8'h61) && (query_char <= 8'h66));

      char_class.is_unreserved = is_digit || is_upper || is_lower ||
                                 (query_char == CH_DASH) ||
                                 (query_char == CH_UNDER) ||
                                 (query_char == CH_DOT);
      char_class.is_hex        = is_digit || is_hex_alpha;
      // letters A-F / a-f sit at low nibble 1..6: add nine to get 10..15
      char_class.hex_value     = is_digit ? query_char[3:0] : query_char[3:0] + 4'd9;
      char_class.is_sep        = (query_char == CH_AMP) || (query_char == CH_SEMI);
      char_class.is_pct        = (query_char == CH_PCT);
      char_class.is_plus       = (query_char == CH_PLUS);
      char_class.is_eq         = (query_char == CH_EQ);
   end

endmodule
